// ===== hw/rtl/sbd_pkg.sv =====
// shared types, constants and divider tables for the spi baud divider search
// used by sbd_ctl, sbd_dp and spi_baud_divider_search; no dependencies
package sbd_pkg;

  // field widths
  localparam int unsigned CLK_W    = 31;
  localparam int unsigned BAUD_W   = 32;
  localparam int unsigned PRE_IW   = 2;
  localparam int unsigned SCL_IW   = 4;
  localparam int unsigned SHIFT_W  = 4;
  localparam int unsigned DIVR_W   = 5;

  // long division of the clock by a small divisor, several bits per cycle
  localparam int unsigned DIV_STEP_BITS = 8;
  localparam int unsigned DIV_STEPS     = BAUD_W / DIV_STEP_BITS;
  localparam int unsigned STEP_W        = $clog2(DIV_STEPS);

  // configuration register indexes and reset values
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_CLOCK = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MASTER_MODE  = 1'd1;
  localparam logic [CLK_W-1:0]     RST_SOURCE_CLOCK = 31'd50000000;
  localparam logic                 RST_MASTER_MODE  = 1'b1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic              load;      // latch request, clear best
    logic              refuse;    // slave mode, no search
    logic              div_init;  // load dividend for current prescaler and factor
    logic              div_step;  // one group of division bits
    logic              scan;      // evaluate one scaler candidate
    logic              finish;    // register result and strobe
    logic [PRE_IW-1:0] pre_idx;
    logic              dbl;
    logic [SCL_IW-1:0] scl_idx;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic master;
  } sts_t;

  // prescaler value 2, 3, 5, 7
  function automatic logic [DIVR_W-1:0] pre_div(input logic [PRE_IW-1:0] idx);
    logic [DIVR_W-1:0] v;
    case (idx)
      2'd0:    v = 5'd2;
      2'd1:    v = 5'd3;
      2'd2:    v = 5'd5;
      default: v = 5'd7;
    endcase
    return v;
  endfunction

  // prescaler times three, for the scaler of six
  function automatic logic [DIVR_W-1:0] pre_div3(input logic [PRE_IW-1:0] idx);
    logic [DIVR_W-1:0] v;
    case (idx)
      2'd0:    v = 5'd6;
      2'd1:    v = 5'd9;
      2'd2:    v = 5'd15;
      default: v = 5'd21;
    endcase
    return v;
  endfunction

  // scaler as a power-of-two shift; the scaler of six shifts the divide-by-three lane
  function automatic logic [SHIFT_W-1:0] scl_shift(input logic [SCL_IW-1:0] idx);
    logic [SHIFT_W-1:0] v;
    case (idx)
      4'd0:    v = 4'd1;
      4'd1:    v = 4'd2;
      4'd2:    v = 4'd1;
      default: v = idx;
    endcase
    return v;
  endfunction

  // scaler of six takes the divide-by-three lane
  function automatic logic scl_odd(input logic [SCL_IW-1:0] idx);
    return (idx == 4'd2);
  endfunction

endpackage

// ===== hw/rtl/sbd_ctl.sv =====
// search controller: sequences division and scaler scan over prescaler and factor
// depends on sbd_pkg
module sbd_ctl
  import sbd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INIT = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [PRE_IW-1:0] pre_r, pre_nxt;
  logic              dbl_r, dbl_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [SCL_IW-1:0] scl_r, scl_nxt;

  assign busy = (state_r != S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    pre_nxt      = pre_r;
    dbl_nxt      = dbl_r;
    step_nxt     = step_r;
    scl_nxt      = scl_r;
    cmd          = '0;
    cmd.pre_idx  = pre_r;
    cmd.dbl      = dbl_r;
    cmd.scl_idx  = scl_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (sts.master) begin
            cmd.div_init = 1'b1;
            step_nxt     = '0;
            state_nxt    = S_DIV;
          end else begin
            cmd.refuse = 1'b1;
            state_nxt  = S_DONE;
          end
        end
      end
      S_INIT: begin
        cmd.div_init = 1'b1;
        step_nxt     = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          scl_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        scl_nxt  = scl_r + 1'b1;
        if (scl_r == {SCL_IW{1'b1}}) begin
          // factor is the inner count, prescaler the outer; both wrap to zero
          {pre_nxt, dbl_nxt} = {pre_r, dbl_r} + 1'b1;
          if ({pre_r, dbl_r} == {(PRE_IW + 1){1'b1}}) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_INIT;
          end
        end
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pre_r   <= '0;
      dbl_r   <= 1'b0;
      step_r  <= '0;
      scl_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pre_r   <= pre_nxt;
      dbl_r   <= dbl_nxt;
      step_r  <= step_nxt;
      scl_r   <= scl_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_slave_short: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && start && !sts.master) |=> (state_r == S_DONE))
    else $error("slave request did not go straight to done");

  a_last_group: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && scl_r == {SCL_IW{1'b1}} && pre_r == {PRE_IW{1'b1}} && dbl_r)
    |=> (state_r == S_DONE && pre_r == '0 && !dbl_r))
    else $error("search did not end after the last group");

  a_div_to_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && step_r == STEP_W'(DIV_STEPS - 1))
    |=> (state_r == S_SCAN && scl_r == '0))
    else $error("scan did not start at the first scaler");
`endif

endmodule

// ===== hw/rtl/sbd_dp.sv =====
// search datapath: config registers, two division lanes, best-candidate tracking
// and result registers; depends on sbd_pkg
module sbd_dp
  import sbd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CLK_W-1:0]     cfg_wdata,
  input  logic [BAUD_W-1:0]    in_requested_baud,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  output logic                 out_valid,
  output logic [BAUD_W-1:0]    out_achieved_baud,
  output logic [PRE_IW-1:0]    out_prescaler_index,
  output logic [SCL_IW-1:0]    out_scaler_index,
  output logic                 out_double_rate,
  output logic                 out_slave_refused
);

  typedef struct packed {
    logic [BAUD_W-1:0] quo;
    logic [DIVR_W-1:0] rem;
  } div_t;

  // a group of restoring long division bits; remainder stays below the divisor
  function automatic div_t div_group(input div_t cur, input logic [DIVR_W-1:0] dv);
    div_t              nx;
    logic [DIVR_W:0]   trial;
    nx = cur;
    for (int i = 0; i < DIV_STEP_BITS; i++) begin
      trial  = {nx.rem, nx.quo[BAUD_W-1]};
      nx.quo = {nx.quo[BAUD_W-2:0], 1'b0};
      if (trial >= {1'b0, dv}) begin
        trial     = trial - {1'b0, dv};
        nx.quo[0] = 1'b1;
      end
      nx.rem = trial[DIVR_W-1:0];
    end
    return nx;
  endfunction

  logic [CLK_W-1:0]  source_clock_r;
  logic              master_r;
  logic              out_valid_r;
  logic [BAUD_W-1:0] req_r;
  div_t              lane1_r, lane3_r;
  logic [BAUD_W-1:0] best_rate_r, best_gap_r;
  logic [PRE_IW-1:0] best_pre_r;
  logic [SCL_IW-1:0] best_scl_r;
  logic              best_dbl_r, best_valid_r, refused_r;
  logic [BAUD_W-1:0] out_achieved_baud_r;
  logic [PRE_IW-1:0] out_prescaler_index_r;
  logic [SCL_IW-1:0] out_scaler_index_r;
  logic              out_double_rate_r, out_slave_refused_r;

  logic [BAUD_W-1:0] dividend;
  div_t              lane1_nxt, lane3_nxt;
  logic [BAUD_W-1:0] cand_src, cand_rate, cand_gap;
  logic              cand_fits, cand_earlier, cand_take;

  assign sts.master = master_r;

  // clock times the double-rate factor, fits in the full width
  assign dividend = cmd.dbl ? {source_clock_r, 1'b0} : {1'b0, source_clock_r};

  assign lane1_nxt = div_group(lane1_r, pre_div(cmd.pre_idx));
  assign lane3_nxt = div_group(lane3_r, pre_div3(cmd.pre_idx));

  // candidate rate for the current scaler, and whether it beats the held best
  always_comb begin
    cand_src     = scl_odd(cmd.scl_idx) ? lane3_r.quo : lane1_r.quo;
    cand_rate    = cand_src >> scl_shift(cmd.scl_idx);
    cand_fits    = (req_r >= cand_rate);
    cand_gap     = req_r - cand_rate;
    // on a tie within one prescaler the lower scaler index wins, then the lower factor
    cand_earlier = ({cmd.scl_idx, cmd.dbl} < {best_scl_r, best_dbl_r});
    cand_take    = cand_fits &&
                   ((cand_gap < best_gap_r) ||
                    (best_valid_r && cand_gap == best_gap_r &&
                     best_pre_r == cmd.pre_idx && cand_earlier));
  end

  // config registers and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_clock_r <= RST_SOURCE_CLOCK;
      master_r       <= RST_MASTER_MODE;
      out_valid_r    <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
      if (cfg_we) begin
        case (cfg_index)
          REG_SOURCE_CLOCK: source_clock_r <= cfg_wdata;
          REG_MASTER_MODE:  master_r       <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  // request, division lanes and best candidate
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r        <= in_requested_baud;
      refused_r    <= cmd.refuse;
      best_rate_r  <= '0;
      best_gap_r   <= '1;
      best_pre_r   <= '0;
      best_scl_r   <= '0;
      best_dbl_r   <= 1'b0;
      best_valid_r <= 1'b0;
    end else if (cmd.scan && cand_take) begin
      best_rate_r  <= cand_rate;
      best_gap_r   <= cand_gap;
      best_pre_r   <= cmd.pre_idx;
      best_scl_r   <= cmd.scl_idx;
      best_dbl_r   <= cmd.dbl;
      best_valid_r <= 1'b1;
    end
    if (cmd.div_init) begin
      lane1_r <= '{quo: dividend, rem: '0};
      lane3_r <= '{quo: dividend, rem: '0};
    end else if (cmd.div_step) begin
      lane1_r <= lane1_nxt;
      lane3_r <= lane3_nxt;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_achieved_baud_r   <= best_rate_r;
      out_prescaler_index_r <= best_pre_r;
      out_scaler_index_r    <= best_scl_r;
      out_double_rate_r     <= best_dbl_r;
      out_slave_refused_r   <= refused_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_achieved_baud   = out_achieved_baud_r;
  assign out_prescaler_index = out_prescaler_index_r;
  assign out_scaler_index    = out_scaler_index_r;
  assign out_double_rate     = out_double_rate_r;
  assign out_slave_refused   = out_slave_refused_r;

`ifndef ASSERT_OFF
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe longer than one cycle");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_slave_refused_r) |-> (out_achieved_baud_r == '0))
    else $error("refused request reports a nonzero rate");

  a_not_above: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_achieved_baud_r <= req_r))
    else $error("reported rate exceeds the request");
`endif

endmodule

// ===== hw/rtl/spi_baud_divider_search.sv =====
// master mode: busy holds off new requests until the result strobe rises, then drops;
// the search runs 8 prescaler/factor groups of division steps (8 quotient bits each)
// and a scan over each scaler candidate, with the division lanes reloaded between groups
// slave mode: straight to the done state, which registers the strobe; busy until then
// synchronous active-low reset: controller idle, source_clock 50000000, master mode on;
// the receiver cannot stall, each result is shown for one cycle only
module spi_baud_divider_search
  import sbd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CLK_W-1:0]     cfg_wdata,
  input  logic                 start,
  output logic                 busy,
  input  logic [BAUD_W-1:0]    in_requested_baud,
  output logic                 out_valid,
  output logic [BAUD_W-1:0]    out_achieved_baud,
  output logic [PRE_IW-1:0]    out_prescaler_index,
  output logic [SCL_IW-1:0]    out_scaler_index,
  output logic                 out_double_rate,
  output logic                 out_slave_refused
);

  cmd_t cmd;
  sts_t sts;

  // search sequencer
  sbd_ctl u_ctl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // division, compare and result datapath
  sbd_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_requested_baud   (in_requested_baud),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_valid           (out_valid),
    .out_achieved_baud   (out_achieved_baud),
    .out_prescaler_index (out_prescaler_index),
    .out_scaler_index    (out_scaler_index),
    .out_double_rate     (out_double_rate),
    .out_slave_refused   (out_slave_refused)
  );

endmodule
